>>> hdl/vlrm_pkg.sv
package vlrm_pkg;

  typedef enum logic {
    ACT_DISP = 1'b0,
    ACT_PAIR = 1'b1
  } action_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SKIN_THRESHOLD      = 2'd0,
    REG_LIST_RADIUS_SQUARED = 2'd1,
    REG_REBUILD_INTERVAL    = 2'd2
  } cfg_reg_e;

  localparam int unsigned SkinWidth   = 31;
  localparam int unsigned RadiusWidth = 31;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned IncWidth    = 32;
  localparam int unsigned DeltaWidth  = 16;
  localparam int unsigned Dist2Width  = 32;

  // store controls: the read for the incoming transaction, the write for the one in the accumulate stage
  typedef struct packed {
    logic rd_en;
    logic rd_live;
    logic wr_en;
  } acc_ctrl_t;

endpackage

>>> hdl/vlrm_acc_store.sv
module vlrm_acc_store #(
  parameter int unsigned MAX_BEADS  = 1024,
  parameter int unsigned DISP_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vlrm_pkg::acc_ctrl_t           ctrl_i,
  input  logic [$clog2(MAX_BEADS)-1:0]  rd_addr_i,
  input  logic [$clog2(MAX_BEADS)-1:0]  wr_addr_i,
  input  logic signed [DISP_WIDTH-1:0]  wr_data_i,
  output logic signed [DISP_WIDTH-1:0]  rd_data_o
);

  logic signed [DISP_WIDTH-1:0] mem [MAX_BEADS];
  logic signed [DISP_WIDTH-1:0] rdata_q;
  logic signed [DISP_WIDTH-1:0] fwd_data_q;
  logic                         fwd_hit_q;
  logic                         live_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // a write at the same edge as the read is not seen by the array read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      live_q    <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_hit_q <= ctrl_i.wr_en && (wr_addr_i == rd_addr_i);
      live_q    <= ctrl_i.rd_live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      fwd_data_q <= wr_data_i;
    end
  end

  // entries beyond the fill mark have not been written since the last clear
  always_comb begin
    if (!live_q) begin
      rd_data_o = '0;
    end else if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else begin
      rd_data_o = rdata_q;
    end
  end

endmodule

>>> hdl/verlet_list_rebuild_monitor_unit.sv
// Verlet neighbor-list skin monitor.
// Input channel (in_valid_i/in_ready_o) carries one item per transaction: a
// displacement increment for the next bead (action 0) or a candidate pair test
// (action 1). Each item yields exactly one result on the output channel
// (out_valid_o/out_ready_i) with rebuild_needed, pair_in_list and sweep_done.
// The accumulator memory is read at the input transaction; the sum is written
// back and the result is registered when the item leaves the accumulate stage.
// Throughput is one item per cycle while the receiver does not stall;
// consecutive beads hitting the same entry are covered by forwarding.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while idle, a
// user's duty the block does not enforce; writing rebuild_interval also reloads
// the next rebuild time. After reset all accumulators read as zero with no
// clearing pass: a fill mark tracks the prefix of entries written since the last
// rebuild, and the end of a pair sweep simply resets that mark. When the
// receiver stalls, the output register holds its result and one more item
// may still be taken into the accumulate stage; beyond that in_ready_o drops.
module verlet_list_rebuild_monitor_unit #(
  parameter int unsigned MAX_BEADS  = 1024,
  parameter int unsigned DISP_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vlrm_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [vlrm_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [vlrm_pkg::IncWidth-1:0]  increment_i,
  input  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_x_i,
  input  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_y_i,
  input  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_z_i,
  input  logic                                  last_of_sweep_i,
  input  logic [vlrm_pkg::TimeWidth-1:0]        current_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  rebuild_needed_o,
  output logic                                  pair_in_list_o,
  output logic                                  sweep_done_o
);

  localparam int unsigned AW   = $clog2(MAX_BEADS);
  localparam int unsigned PW   = $clog2(MAX_BEADS + 1);
  localparam int unsigned DW   = DISP_WIDTH;
  localparam int unsigned SW   = ((DW > vlrm_pkg::IncWidth) ? DW : vlrm_pkg::IncWidth) + 1;
  localparam int unsigned CMPW = (DW > vlrm_pkg::SkinWidth) ? DW : vlrm_pkg::SkinWidth;

  localparam logic signed [SW-1:0] SatHi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SatLo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // configuration
  logic [vlrm_pkg::SkinWidth-1:0]   skin_q;
  logic [vlrm_pkg::RadiusWidth-1:0] radius2_q;
  logic [vlrm_pkg::TimeWidth-1:0]   interval_q;

  // front state, advanced at the input transaction
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] fill_q, fill_d;

  // accumulate stage
  logic                                   s1_valid_q;
  vlrm_pkg::action_e                      s1_action_q;
  logic                                   s1_last_q;
  logic                                   s1_acc_q;
  logic [AW-1:0]                          s1_addr_q;
  logic signed [vlrm_pkg::IncWidth-1:0]   s1_inc_q;
  logic signed [vlrm_pkg::DeltaWidth-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic [vlrm_pkg::TimeWidth-1:0]         s1_time_q;

  // tracking state, updated by the accumulate stage (next_time_q also by a rebuild_interval write)
  logic signed [DW-1:0]           largest_q, largest_d;
  logic signed [DW-1:0]           second_q, second_d;
  logic                           flag_q, flag_d;
  logic [vlrm_pkg::TimeWidth-1:0] next_time_q, next_time_d;

  // output register
  logic out_valid_q;
  logic rebuild_q, rebuild_d;
  logic in_list_q, in_list_d;
  logic done_q;

  logic in_fire, s1_adv, s1_fire, bead_ok;
  logic signed [DW-1:0] old_total, new_total;
  logic signed [SW-1:0] raw_sum;
  logic [DW-1:0]        top_sum;
  logic signed [31:0]   sq_x, sq_y, sq_z;
  logic [vlrm_pkg::Dist2Width-1:0] dist2;
  vlrm_pkg::acc_ctrl_t  acc_ctrl;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign bead_ok    = pos_q < PW'(MAX_BEADS);

  assign acc_ctrl.rd_en   = in_fire && (action_i == vlrm_pkg::ACT_DISP) && bead_ok;
  assign acc_ctrl.rd_live = pos_q < fill_q;
  assign acc_ctrl.wr_en   = s1_fire && (s1_action_q == vlrm_pkg::ACT_DISP) && s1_acc_q;

  vlrm_acc_store #(
    .MAX_BEADS  (MAX_BEADS),
    .DISP_WIDTH (DISP_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .rd_addr_i (pos_q[AW-1:0]),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_total),
    .rd_data_o (old_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skin_q     <= '0;
      radius2_q  <= '0;
      interval_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vlrm_pkg::REG_SKIN_THRESHOLD:
          skin_q <= cfg_data_i[vlrm_pkg::SkinWidth-1:0];
        vlrm_pkg::REG_LIST_RADIUS_SQUARED:
          radius2_q <= cfg_data_i[vlrm_pkg::RadiusWidth-1:0];
        vlrm_pkg::REG_REBUILD_INTERVAL:
          interval_q <= cfg_data_i[vlrm_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // bead order and fill mark depend only on the item kind and last flag, not on the sums, so they run ahead
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (in_fire) begin
      if (action_i == vlrm_pkg::ACT_DISP) begin
        if (bead_ok) begin
          pos_d = pos_q + PW'(1);
          if (pos_q >= fill_q) begin
            fill_d = pos_q + PW'(1);
          end
        end
        if (last_of_sweep_i) begin
          pos_d = '0;
        end
      end else if (last_of_sweep_i) begin
        pos_d  = '0;
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= vlrm_pkg::action_e'(action_i);
      s1_last_q   <= last_of_sweep_i;
      s1_acc_q    <= bead_ok;
      s1_addr_q   <= pos_q[AW-1:0];
      s1_inc_q    <= increment_i;
      s1_dx_q     <= delta_x_i;
      s1_dy_q     <= delta_y_i;
      s1_dz_q     <= delta_z_i;
      s1_time_q   <= current_time_i;
    end
  end

  // saturating accumulate
  always_comb begin
    raw_sum = {{(SW-DW){old_total[DW-1]}}, old_total}
            + {{(SW-vlrm_pkg::IncWidth){s1_inc_q[vlrm_pkg::IncWidth-1]}}, s1_inc_q};
    if (raw_sum > SatHi) begin
      new_total = SatHi[DW-1:0];
    end else if (raw_sum < SatLo) begin
      new_total = SatLo[DW-1:0];
    end else begin
      new_total = raw_sum[DW-1:0];
    end
  end

  assign sq_x  = 32'(s1_dx_q) * 32'(s1_dx_q);
  assign sq_y  = 32'(s1_dy_q) * 32'(s1_dy_q);
  assign sq_z  = 32'(s1_dz_q) * 32'(s1_dz_q);
  assign dist2 = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

  always_comb begin
    largest_d   = largest_q;
    second_d    = second_q;
    flag_d      = flag_q;
    next_time_d = next_time_q;
    in_list_d   = 1'b0;
    top_sum     = '0;
    if (s1_action_q == vlrm_pkg::ACT_DISP) begin
      if (s1_acc_q) begin
        if (new_total >= largest_q) begin
          second_d  = largest_q;
          largest_d = new_total;
        end else if (new_total >= second_q) begin
          second_d = new_total;
        end
      end
      // both trackers are non-negative, so their sum fits unsigned
      top_sum = $unsigned(largest_d) + $unsigned(second_d);
      if (s1_last_q) begin
        if (CMPW'(top_sum) > CMPW'(skin_q)) begin
          flag_d = 1'b1;
        end
        largest_d = '0;
        second_d  = '0;
      end
    end else begin
      in_list_d = dist2 <= {1'b0, radius2_q};
      if (s1_last_q) begin
        flag_d      = 1'b0;
        next_time_d = next_time_q + interval_q;
        largest_d   = '0;
        second_d    = '0;
      end
    end
    rebuild_d = (s1_time_q >= next_time_d) || flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q   <= '0;
      second_q    <= '0;
      flag_q      <= 1'b0;
      next_time_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == vlrm_pkg::REG_REBUILD_INTERVAL)) begin
      next_time_q <= cfg_data_i[vlrm_pkg::TimeWidth-1:0];
    end else if (s1_fire) begin
      largest_q   <= largest_d;
      second_q    <= second_d;
      flag_q      <= flag_d;
      next_time_q <= next_time_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rebuild_q <= rebuild_d;
      in_list_q <= in_list_d;
      done_q    <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rebuild_needed_o = rebuild_q;
  assign pair_in_list_o   = in_list_q;
  assign sweep_done_o     = done_q;

endmodule

>>> test/verlet_list_rebuild_monitor_unit_tb.sv
module verlet_list_rebuild_monitor_unit_tb;

  localparam int unsigned NumBeads    = 1024;
  localparam int unsigned RandomItems = 150;
  localparam logic [vlrm_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam longint DispMax = 64'sd2147483647;
  localparam longint DispMin = -64'sd2147483648;

  typedef logic signed [vlrm_pkg::DeltaWidth-1:0] delta_t;

  typedef struct {
    vlrm_pkg::action_e                      action;
    logic signed [vlrm_pkg::IncWidth-1:0]   increment;
    logic signed [vlrm_pkg::DeltaWidth-1:0] delta_x;
    logic signed [vlrm_pkg::DeltaWidth-1:0] delta_y;
    logic signed [vlrm_pkg::DeltaWidth-1:0] delta_z;
    logic                                   last;
    logic [vlrm_pkg::TimeWidth-1:0]         now;
  } md_item_t;

  typedef struct packed {
    logic rebuild_needed;
    logic pair_in_list;
    logic sweep_done;
  } monitor_status_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [vlrm_pkg::CfgIdxWidth-1:0] cfg_index_i;
  logic [vlrm_pkg::CfgDataWidth-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic action_i;
  logic signed [vlrm_pkg::IncWidth-1:0] increment_i;
  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_x_i;
  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_y_i;
  logic signed [vlrm_pkg::DeltaWidth-1:0] delta_z_i;
  logic last_of_sweep_i;
  logic [vlrm_pkg::TimeWidth-1:0] current_time_i;
  logic out_valid_o;
  logic out_ready_i;
  logic rebuild_needed_o;
  logic pair_in_list_o;
  logic sweep_done_o;

  verlet_list_rebuild_monitor_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .increment_i      (increment_i),
    .delta_x_i        (delta_x_i),
    .delta_y_i        (delta_y_i),
    .delta_z_i        (delta_z_i),
    .last_of_sweep_i  (last_of_sweep_i),
    .current_time_i   (current_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rebuild_needed_o (rebuild_needed_o),
    .pair_in_list_o   (pair_in_list_o),
    .sweep_done_o     (sweep_done_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the monitor state and its registers
  logic [vlrm_pkg::SkinWidth-1:0]   skin_q;
  logic [vlrm_pkg::RadiusWidth-1:0] radius2_q;
  logic [vlrm_pkg::TimeWidth-1:0]   interval_q;
  logic [vlrm_pkg::TimeWidth-1:0]   next_rebuild_q;
  longint                           bead_total [NumBeads];
  int unsigned                      bead_idx;
  longint                           top_first;
  longint                           top_second;
  bit                               drift_flag;

  monitor_status_t pending_status [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 8;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;

  function automatic void clear_sweep();
    bead_idx   = 0;
    top_first  = 0;
    top_second = 0;
  endfunction

  function automatic void clear_totals();
    foreach (bead_total[i]) bead_total[i] = 0;
  endfunction

  function automatic void apply_reg_write(logic [vlrm_pkg::CfgIdxWidth-1:0] idx,
                                          logic [vlrm_pkg::CfgDataWidth-1:0] data);
    case (idx)
      vlrm_pkg::REG_SKIN_THRESHOLD:      skin_q = data[vlrm_pkg::SkinWidth-1:0];
      vlrm_pkg::REG_LIST_RADIUS_SQUARED: radius2_q = data[vlrm_pkg::RadiusWidth-1:0];
      vlrm_pkg::REG_REBUILD_INTERVAL: begin
        interval_q     = data[vlrm_pkg::TimeWidth-1:0];
        next_rebuild_q = data[vlrm_pkg::TimeWidth-1:0];
      end
      default: ;
    endcase
  endfunction

  // applies one transaction to the shadow state and returns the status it yields
  function automatic monitor_status_t advance_skin_monitor(md_item_t it);
    monitor_status_t st;
    longint t;
    longint dx;
    longint dy;
    longint dz;
    longint dist2;
    st = '0;
    if (it.action == vlrm_pkg::ACT_DISP) begin
      if (bead_idx < NumBeads) begin
        t = bead_total[bead_idx] + longint'(it.increment);
        if (t > DispMax) t = DispMax;
        else if (t < DispMin) t = DispMin;
        bead_total[bead_idx] = t;
        if (t >= top_first) begin
          top_second = top_first;
          top_first  = t;
        end else if (t >= top_second) begin
          top_second = t;
        end
        bead_idx++;
      end
      if (it.last) begin
        if (top_first + top_second > longint'(skin_q)) drift_flag = 1'b1;
        clear_sweep();
      end
    end else begin
      dx = longint'(it.delta_x);
      dy = longint'(it.delta_y);
      dz = longint'(it.delta_z);
      dist2 = dx * dx + dy * dy + dz * dz;
      st.pair_in_list = (dist2 <= longint'(radius2_q));
      if (it.last) begin
        clear_totals();
        drift_flag     = 1'b0;
        next_rebuild_q = next_rebuild_q + interval_q;
        clear_sweep();
      end
    end
    st.rebuild_needed = (it.now >= next_rebuild_q) || drift_flag;
    st.sweep_done     = it.last;
    return st;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    mismatches++;
    $display("mismatch at %0t: %s got %b expected %b", $time, what, got, want);
  endtask

  task automatic check_result();
    monitor_status_t want;
    if (pending_status.size() == 0) begin
      report_mismatch("result with no transaction outstanding", 1'b1, 1'b0);
      return;
    end
    want = pending_status.pop_front();
    if (rebuild_needed_o !== want.rebuild_needed)
      report_mismatch("rebuild_needed", rebuild_needed_o, want.rebuild_needed);
    if (pair_in_list_o !== want.pair_in_list)
      report_mismatch("pair_in_list", pair_in_list_o, want.pair_in_list);
    if (sweep_done_o !== want.sweep_done)
      report_mismatch("sweep_done", sweep_done_o, want.sweep_done);
  endtask

  // receiver: checks each result under a changing random stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_cycle % 8 != 0);
    endcase
  end

  task automatic send_item(md_item_t it);
    in_valid_i      <= 1'b1;
    action_i        <= it.action;
    increment_i     <= it.increment;
    delta_x_i       <= it.delta_x;
    delta_y_i       <= it.delta_y;
    delta_z_i       <= it.delta_z;
    last_of_sweep_i <= it.last;
    current_time_i  <= it.now;
    do @(posedge clk_i); while (!in_ready_o);
    pending_status = {pending_status, advance_skin_monitor(it)};
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vlrm_pkg::CfgIdxWidth-1:0] idx,
                           logic [vlrm_pkg::CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [vlrm_pkg::CfgDataWidth-1:0] skin,
                           logic [vlrm_pkg::CfgDataWidth-1:0] radius2,
                           logic [vlrm_pkg::CfgDataWidth-1:0] interval);
    wait_drained();
    write_reg(vlrm_pkg::REG_SKIN_THRESHOLD, skin);
    write_reg(vlrm_pkg::REG_LIST_RADIUS_SQUARED, radius2);
    write_reg(vlrm_pkg::REG_REBUILD_INTERVAL, interval);
  endtask

  // unused fields still carry random values
  function automatic md_item_t disp_item(logic signed [vlrm_pkg::IncWidth-1:0] inc,
                                         logic last,
                                         logic [vlrm_pkg::TimeWidth-1:0] now);
    md_item_t it;
    it.action    = vlrm_pkg::ACT_DISP;
    it.increment = inc;
    it.delta_x   = delta_t'($urandom());
    it.delta_y   = delta_t'($urandom());
    it.delta_z   = delta_t'($urandom());
    it.last      = last;
    it.now       = now;
    return it;
  endfunction

  function automatic md_item_t pair_item(logic signed [vlrm_pkg::DeltaWidth-1:0] dx,
                                         logic signed [vlrm_pkg::DeltaWidth-1:0] dy,
                                         logic signed [vlrm_pkg::DeltaWidth-1:0] dz,
                                         logic last,
                                         logic [vlrm_pkg::TimeWidth-1:0] now);
    md_item_t it;
    it.action    = vlrm_pkg::ACT_PAIR;
    it.increment = $urandom();
    it.delta_x   = dx;
    it.delta_y   = dy;
    it.delta_z   = dz;
    it.last      = last;
    it.now       = now;
    return it;
  endfunction

  // times cluster around the scheduled rebuild so both outcomes occur
  function automatic logic [vlrm_pkg::TimeWidth-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return next_rebuild_q;
      2: return next_rebuild_q - 1;
      default: return next_rebuild_q + $urandom_range(0, 64) - 32;
    endcase
  endfunction

  function automatic logic signed [vlrm_pkg::IncWidth-1:0] rand_increment();
    logic signed [vlrm_pkg::IncWidth-1:0] v;
    int unsigned k;
    k = $urandom_range(1, 31);
    if ($urandom_range(0, 9) == 0) return $urandom();
    v = $urandom() >> (32 - k);
    return ($urandom_range(0, 3) == 0) ? -v : v;
  endfunction

  function automatic logic signed [vlrm_pkg::DeltaWidth-1:0] rand_delta();
    logic signed [vlrm_pkg::DeltaWidth-1:0] v;
    int unsigned k;
    k = $urandom_range(1, 15);
    if ($urandom_range(0, 3) == 0) return delta_t'($urandom());
    v = delta_t'($urandom() >> (32 - k));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [vlrm_pkg::CfgDataWidth-1:0] pick_reg_value(
      logic [vlrm_pkg::CfgDataWidth-1:0] top);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return top;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(8, 28);
    endcase
  endfunction

  task automatic test_field_extremes();
    // data bit 31 must be dropped by the 31-bit registers
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(pair_item(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 32'h0000_0000));
    send_item(pair_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 32'hFFFF_FFFF));
    send_item(pair_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'hFFFF_FFFE));
    send_item(disp_item(32'sh7FFF_FFFF, 1'b0, 32'h0000_0000));
    send_item(disp_item(32'sh8000_0000, 1'b0, 32'hFFFF_FFFF));
    // top two sum equals the skin exactly, so no flag
    send_item(disp_item(32'sh0000_0000, 1'b1, 32'h0000_0000));
    send_item(pair_item(16'sh0001, 16'sh0001, 16'sh0001, 1'b1, 32'h0000_0000));
    // radius boundary: equal is inside
    configure(32'h0000_0000, 32'd196608, 32'd50);
    send_item(pair_item(16'sd256, 16'sd256, 16'sd256, 1'b0, 32'd10));
    send_item(pair_item(-16'sd256, 16'sd256, -16'sd257, 1'b0, 32'd49));
    send_item(pair_item(16'sd256, -16'sd256, 16'sd256, 1'b1, 32'd50));
  endtask

  task automatic test_saturation();
    configure(32'h7FFF_FFFE, 32'd65536, 32'd1000);
    send_item(disp_item(32'sh7FFF_FFFF, 1'b0, 32'd0));
    send_item(disp_item(32'sh8000_0000, 1'b1, 32'd0));
    send_item(disp_item(32'sh7FFF_FFFF, 1'b0, 32'd0));
    send_item(disp_item(32'sh8000_0000, 1'b1, 32'd0));
    send_item(pair_item(16'sd1, 16'sd2, 16'sd3, 1'b1, 32'd0));
    send_item(disp_item(32'sd1, 1'b0, 32'd0));
    send_item(disp_item(32'sh7FFF_FFFE, 1'b1, 32'd0));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd0));
  endtask

  task automatic test_negative_totals();
    configure(32'd0, 32'd65536, 32'd100000);
    send_item(disp_item(-32'sd5, 1'b0, 32'd0));
    send_item(disp_item(-32'sd100, 1'b0, 32'd0));
    send_item(disp_item(32'sh8000_0000, 1'b1, 32'd0));
    send_item(disp_item(32'sd0, 1'b0, 32'd0));
    send_item(disp_item(32'sd0, 1'b1, 32'd0));
    // bead 0 climbs from -5 to +1
    send_item(disp_item(32'sd6, 1'b1, 32'd0));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd0));
  endtask

  task automatic test_mixed_items();
    configure(32'd1000, 32'd262144, 32'd100);
    send_item(disp_item(32'sd300, 1'b0, 32'd5));
    send_item(pair_item(16'sd256, 16'sd0, 16'sd0, 1'b0, 32'd5));
    send_item(disp_item(32'sd400, 1'b0, 32'd5));
    send_item(pair_item(16'sd512, 16'sd1, 16'sd0, 1'b0, 32'd5));
    send_item(disp_item(32'sd500, 1'b1, 32'd5));
    send_item(disp_item(32'sd700, 1'b0, 32'd99));
    // pair sweep ends inside a displacement sweep and restarts it
    send_item(pair_item(16'sd0, 16'sd0, -16'sd512, 1'b1, 32'd150));
    send_item(disp_item(32'sd600, 1'b0, 32'd199));
    send_item(disp_item(32'sd500, 1'b1, 32'd199));
    send_item(pair_item(16'sd100, 16'sd100, 16'sd100, 1'b1, 32'd200));
  endtask

  task automatic test_time_wrap();
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hC000_0000);
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b0, 32'hBFFF_FFFF));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'h9000_0000));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'h1000_0000));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'h0000_0000));
    send_item(disp_item(32'sd1, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_unused_register();
    wait_drained();
    write_reg(RegUnused, $urandom());
    write_reg(RegUnused, '1);
    send_item(disp_item(32'sd7, 1'b1, pick_time()));
    send_item(pair_item(16'sd3, 16'sd4, 16'sd5, 1'b1, pick_time()));
  endtask

  task automatic test_bead_overflow();
    configure(32'd10, 32'd65536, 32'd500);
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd0));
    // beads past the store are ignored even with huge increments
    for (int unsigned i = 0; i < NumBeads + 6; i++)
      send_item(disp_item((i < NumBeads) ? 32'sd1 : 32'sh7FFF_FFFF,
                          i == NumBeads + 5, pick_time()));
    send_item(disp_item(32'sd5, 1'b0, pick_time()));
    send_item(disp_item(32'sd5, 1'b1, pick_time()));
    send_item(pair_item(16'sd0, 16'sd0, 16'sd0, 1'b1, pick_time()));
  endtask

  task automatic random_disp_sweep();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(pair_item(rand_delta(), rand_delta(), rand_delta(),
                            $urandom_range(0, 19) == 0, pick_time()));
      send_item(disp_item(rand_increment(), i == len - 1, pick_time()));
    end
  endtask

  task automatic random_pair_sweep();
    int unsigned len;
    len = $urandom_range(1, 20);
    for (int unsigned i = 0; i < len; i++)
      send_item(pair_item(rand_delta(), rand_delta(), rand_delta(), i == len - 1, pick_time()));
  endtask

  task automatic random_noise_item();
    md_item_t it;
    it.action    = vlrm_pkg::action_e'($urandom_range(0, 1));
    it.increment = $urandom();
    it.delta_x   = delta_t'($urandom());
    it.delta_y   = delta_t'($urandom());
    it.delta_z   = delta_t'($urandom());
    it.last      = ($urandom_range(0, 3) == 0);
    it.now       = $urandom_range(0, 1) ? $urandom() : pick_time();
    send_item(it);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned phase_end;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < RandomItems) begin
      wait_drained();
      write_reg(vlrm_pkg::REG_SKIN_THRESHOLD, pick_reg_value(32'h7FFF_FFFF));
      write_reg(vlrm_pkg::REG_LIST_RADIUS_SQUARED, pick_reg_value(32'h7FFF_FFFF));
      write_reg(vlrm_pkg::REG_REBUILD_INTERVAL, pick_reg_value(32'hFFFF_FFFF));
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + $urandom_range(40, 80);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) random_disp_sweep();
        else if (pick < 17) random_pair_sweep();
        else random_noise_item();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    action_i        <= 1'b0;
    increment_i     <= '0;
    delta_x_i       <= '0;
    delta_y_i       <= '0;
    delta_z_i       <= '0;
    last_of_sweep_i <= 1'b0;
    current_time_i  <= '0;
    skin_q          = '0;
    radius2_q       = '0;
    interval_q      = '0;
    next_rebuild_q  = '0;
    drift_flag      = 1'b0;
    clear_totals();
    clear_sweep();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_saturation();
    test_negative_totals();
    test_mixed_items();
    test_time_wrap();
    test_unused_register();
    test_bead_overflow();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
